// ===== sv/rgbhsv_pkg.sv =====
// Shared constants and types for the RGB to HSV pixel converter.
package rgbhsv_pkg;

  // Width of one color component and of every result field.
  localparam int COMP_W = 8;
  localparam int OUT_W  = 15;

  // Largest component value; the value field divides by it.
  localparam logic [COMP_W-1:0] COMP_MAX = 8'd255;

  // Lanes of the shared divider pipeline.
  localparam int NLANE    = 2;
  localparam int LANE_HUE = 0;
  localparam int LANE_SAT = 1;

  // Hue sector codes: which component holds the maximum.
  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  // Control bits and the finished value field that travel beside the quotients.
  typedef struct packed {
    logic             neg;
    logic [1:0]       sector;
    logic             chromatic;
    logic [OUT_W-1:0] value;
  } side_t;

  // One finished result word.
  typedef struct packed {
    logic [OUT_W-1:0] hue;
    logic [OUT_W-1:0] saturation;
    logic [OUT_W-1:0] value;
    logic             chromatic;
  } hsv_t;

endpackage

// ===== sv/rgbhsv_if.sv =====
// Stream interfaces for RGB pixel words and HSV result words.
interface rgbhsv_rgb_if import rgbhsv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COMP_W-1:0] red;
  logic [COMP_W-1:0] green;
  logic [COMP_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsv_hsv_if import rgbhsv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] hue;
  logic [OUT_W-1:0] saturation;
  logic [OUT_W-1:0] value;
  logic             chromatic;

  modport source (output valid, output hue, output saturation, output value,
                  output chromatic, input ready);
  modport sink (input valid, input hue, input saturation, input value,
                input chromatic, output ready);
endinterface

// ===== sv/rgbhsv_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for each lane.
module rgbhsv_div import rgbhsv_pkg::*; #(
  parameter int QW = 15
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  side_t                   in_side,
  input  logic [QW+COMP_W-1:0]    in_num [NLANE],
  input  logic [COMP_W-1:0]       in_den [NLANE],
  output logic                    out_valid,
  output side_t                   out_side,
  output logic [QW-1:0]           out_quot [NLANE]
);

  localparam int NW = QW + COMP_W;

  // Stage k holds the partial remainder in its top bits, the numerator bits
  // still to be consumed below it, and the quotient bits found so far.
  logic [NW-1:0]     acc  [QW+1][NLANE];
  logic [COMP_W-1:0] den  [QW][NLANE];
  side_t             side [QW+1];
  logic [QW:0]       vld;

  // One restoring step: bring down the next numerator bit and try a subtract.
  // The caller guarantees the top COMP_W bits stay below the divisor.
  function automatic logic [NW-1:0] div_step(input logic [NW-1:0] a,
                                             input logic [COMP_W-1:0] d);
    logic [COMP_W:0]   t;
    logic [COMP_W:0]   dif;
    logic              q;
    logic [COMP_W-1:0] rem;
    t   = a[NW-1:QW-1];
    dif = t - {1'b0, d};
    q   = (t >= {1'b0, d});
    rem = q ? dif[COMP_W-1:0] : t[COMP_W-1:0];
    return {rem, a[QW-2:0], q};
  endfunction

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-1:0], in_valid};
    end
  end

  // Load the first stage and run every division step in parallel stages.
  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      for (int l = 0; l < NLANE; l++) begin
        acc[0][l] <= in_num[l];
        den[0][l] <= in_den[l];
      end
      for (int k = 0; k < QW; k++) begin
        side[k+1] <= side[k];
        for (int l = 0; l < NLANE; l++) begin
          acc[k+1][l] <= div_step(acc[k][l], den[k][l]);
          if (k < QW - 1) begin
            den[k+1][l] <= den[k][l];
          end
        end
      end
    end
  end

  // After the last step the low bits hold the quotient.
  assign out_valid = vld[QW];
  assign out_side  = side[QW];
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      out_quot[l] = acc[QW][l][QW-1:0];
    end
  end

endmodule

// ===== sv/rgb_to_hsv_pixel_convert.sv =====
// Top level of the RGB to HSV pixel converter.
//
//   Port    Dir  Word                                  Accepted when
//   pixel   in   red, green, blue (8 bits each)        pixel.valid && pixel.ready
//   hsv     out  hue, saturation, value (15 bits),     hsv.valid && hsv.ready
//                chromatic (1 bit)
//
// One pixel is taken in every clock cycle while pixel.ready is high. A pixel
// taken passes through one input stage, QW + 1 divider stages and the output
// register before its result word is on hsv, where QW = max(HUE_FRAC_BITS + 6,
// PCT_FRAC_BITS + 7) is the number of bit-per-stage divider steps. Reset
// clears all valid bits; nothing else is kept. When the output is stalled a
// skid register catches one more word, after which pixel.ready drops and the
// whole pipeline holds.
module rgb_to_hsv_pixel_convert import rgbhsv_pkg::*; #(
  parameter int HUE_FRAC_BITS = 6,
  parameter int PCT_FRAC_BITS = 8
) (
  input logic          clk,
  input logic          rst,
  rgbhsv_rgb_if.sink   pixel,
  rgbhsv_hsv_if.source hsv
);

  localparam int HQ = HUE_FRAC_BITS + 6;
  localparam int PQ = PCT_FRAC_BITS + 7;
  localparam int QW = (HQ > PQ) ? HQ : PQ;
  localparam int NW = QW + COMP_W;
  localparam int HW = HUE_FRAC_BITS + 10;
  localparam int PW = 2 * COMP_W;

  localparam logic [NW-1:0] HUE_SCALE = NW'(60) << HUE_FRAC_BITS;
  localparam logic [NW-1:0] PCT_SCALE = NW'(100) << PCT_FRAC_BITS;
  localparam logic [HW-1:0] HUE_OFF_G = HW'(120) << HUE_FRAC_BITS;
  localparam logic [HW-1:0] HUE_OFF_B = HW'(240) << HUE_FRAC_BITS;
  localparam logic [HW-1:0] HUE_FULL  = HW'(360) << HUE_FRAC_BITS;

  // The value scale split into whole multiples of 255 and a remainder.
  localparam int VAL_N = 100 << PCT_FRAC_BITS;
  localparam int VAL_Q = VAL_N / int'(COMP_MAX);
  localparam int VAL_R = VAL_N % int'(COMP_MAX);
  localparam logic [NW-1:0]     VAL_QC = NW'(VAL_Q);
  localparam logic [COMP_W-1:0] VAL_RC = COMP_W'(VAL_R);

  logic en;

  // Stage A: max, min, sector, chroma and the signed hue difference.
  logic [COMP_W-1:0] r, g, b;
  logic [1:0]        sec;
  logic [COMP_W-1:0] mx, mn;
  logic [COMP_W:0]   dif;
  logic              a_v;
  logic [1:0]        a_sector;
  logic [COMP_W-1:0] a_mx;
  logic [COMP_W-1:0] a_chroma;
  logic [COMP_W:0]   a_diff;

  assign r = pixel.red;
  assign g = pixel.green;
  assign b = pixel.blue;

  // Ties go to red first, then green.
  always_comb begin
    priority if (r >= g && r >= b) begin
      sec = SEC_RED;
    end else if (g >= b) begin
      sec = SEC_GREEN;
    end else begin
      sec = SEC_BLUE;
    end
  end

  always_comb begin
    unique case (sec)
      SEC_RED: begin
        mx  = r;
        dif = {1'b0, g} - {1'b0, b};
      end
      SEC_GREEN: begin
        mx  = g;
        dif = {1'b0, b} - {1'b0, r};
      end
      default: begin
        mx  = b;
        dif = {1'b0, r} - {1'b0, g};
      end
    endcase
  end

  always_comb begin
    priority if (r <= g && r <= b) begin
      mn = r;
    end else if (g <= b) begin
      mn = g;
    end else begin
      mn = b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sector <= sec;
      a_mx     <= mx;
      a_chroma <= mx - mn;
      a_diff   <= dif;
    end
  end

  // Stage B: scaled numerators and divisors for the two divisions, and the value field.
  logic [COMP_W:0]   neg_diff;
  logic [COMP_W-1:0] abs_diff;
  side_t             b_side;
  logic [NW-1:0]     b_num [NLANE];
  logic [COMP_W-1:0] b_den [NLANE];
  logic [PW-1:0]     val_y;
  logic [PW-1:0]     val_fix;
  logic [NW-1:0]     val_full;

  assign neg_diff = -a_diff;
  assign abs_diff = a_diff[COMP_W] ? neg_diff[COMP_W-1:0] : a_diff[COMP_W-1:0];

  // Value: max times the whole part of the scale, plus the remainder product
  // divided by 255 as (y + (y >> 8) + 1) >> 8, exact for y below 65280.
  assign val_y    = PW'(a_mx) * PW'(VAL_RC);
  assign val_fix  = val_y + (val_y >> COMP_W) + PW'(1);
  assign val_full = NW'(a_mx) * VAL_QC + NW'(val_fix[PW-1:COMP_W]);

  always_comb begin
    b_side.neg       = a_diff[COMP_W];
    b_side.sector    = a_sector;
    b_side.chromatic = (a_chroma != '0);
    b_side.value     = OUT_W'(val_full);
    b_num[LANE_HUE]  = NW'(abs_diff) * HUE_SCALE;
    b_den[LANE_HUE]  = a_chroma;
    b_num[LANE_SAT]  = NW'(a_chroma) * PCT_SCALE;
    b_den[LANE_SAT]  = a_mx;
  end

  // Divider pipeline carries the valid bit and sideband for each word.
  logic          d_valid;
  side_t         d_side;
  logic [QW-1:0] d_quot [NLANE];

  rgbhsv_div #(
    .QW (QW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (a_v),
    .in_side   (b_side),
    .in_num    (b_num),
    .in_den    (b_den),
    .out_valid (d_valid),
    .out_side  (d_side),
    .out_quot  (d_quot)
  );

  // Final hue: apply sign, add the sector offset and wrap negatives.
  logic [HW-1:0] hue_mag;
  logic [HW-1:0] hue_off;
  logic [HW-1:0] hue_sum;
  logic [HW-1:0] hue_wrap;
  hsv_t          fin;

  assign hue_mag = HW'(d_quot[LANE_HUE]);

  always_comb begin
    unique case (d_side.sector)
      SEC_RED:   hue_off = '0;
      SEC_GREEN: hue_off = HUE_OFF_G;
      default:   hue_off = HUE_OFF_B;
    endcase
  end

  assign hue_sum  = (d_side.neg ? -hue_mag : hue_mag) + hue_off;
  assign hue_wrap = hue_sum[HW-1] ? hue_sum + HUE_FULL : hue_sum;

  // A grey pixel has no hue and no saturation.
  always_comb begin
    fin.chromatic  = d_side.chromatic;
    fin.hue        = d_side.chromatic ? OUT_W'(hue_wrap) : '0;
    fin.saturation = d_side.chromatic ? OUT_W'(d_quot[LANE_SAT]) : '0;
    fin.value      = d_side.value;
  end

  // Output register with a skid register behind it.
  logic o_v;
  logic skid_v;
  hsv_t oreg;
  hsv_t skid;
  logic out_fire;
  logic inc;

  assign en          = !skid_v;
  assign pixel.ready = en;
  assign out_fire    = o_v && hsv.ready;
  assign inc         = en && d_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v    <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      priority if (skid_v) begin
        if (out_fire) begin
          skid_v <= 1'b0;
        end
      end else if (inc) begin
        if (!o_v || out_fire) begin
          o_v <= 1'b1;
        end else begin
          skid_v <= 1'b1;
        end
      end else if (out_fire) begin
        o_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (skid_v) begin
      if (out_fire) begin
        oreg <= skid;
      end
    end else if (inc) begin
      if (!o_v || out_fire) begin
        oreg <= fin;
      end else begin
        skid <= fin;
      end
    end
  end

  assign hsv.valid      = o_v;
  assign hsv.hue        = oreg.hue;
  assign hsv.saturation = oreg.saturation;
  assign hsv.value      = oreg.value;
  assign hsv.chromatic  = oreg.chromatic;

endmodule
